/* rtl/core/afr_pkg.sv */
// Package for the addressed frame receiver: byte type, frame marker bytes
// and the frame and reply position codes. Has no dependencies.
`timescale 1ns / 1ps

package afr_pkg;

    // One serial byte.
    typedef logic [7:0] byte_t;

    // Position counters for the frame parser and the error reply.
    typedef logic [2:0] pos_t;

    // Marker bytes of the frame protocol.
    localparam byte_t START_BYTE = 8'h55;
    localparam byte_t CMD_BYTE   = 8'hC5;
    localparam byte_t TRAIL_BYTE = 8'hAA;
    localparam byte_t ERR_BYTE   = 8'hEE;

    // Constant part of the reply checksum: start, error and trailer bytes.
    localparam byte_t REPLY_SUM_BASE = START_BYTE + ERR_BYTE + TRAIL_BYTE;

    // Operation codes of an input request.
    localparam logic OP_RX_BYTE = 1'b0;
    localparam logic OP_TX_DONE = 1'b1;

    // Frame parser positions: the next frame byte expected.
    localparam pos_t FP_START = 3'd0;
    localparam pos_t FP_ADDR  = 3'd1;
    localparam pos_t FP_CMD   = 3'd2;
    localparam pos_t FP_HIGH  = 3'd3;
    localparam pos_t FP_LOW   = 3'd4;
    localparam pos_t FP_TRAIL = 3'd5;
    localparam pos_t FP_SUM   = 3'd6;

    // Error reply positions: the next reply byte to send.
    localparam pos_t RP_IDLE  = 3'd0;
    localparam pos_t RP_ADDR  = 3'd1;
    localparam pos_t RP_ERR   = 3'd2;
    localparam pos_t RP_TRAIL = 3'd3;
    localparam pos_t RP_SUM   = 3'd4;

endpackage

/* rtl/core/afr_in_if.sv */
// Input channel of the addressed frame receiver: valid/ready handshake with
// the operation code and received byte. Depends on afr_pkg.
`timescale 1ns / 1ps

interface afr_in_if
    import afr_pkg::*;
();
    logic  valid;
    logic  ready;
    logic  operation;
    byte_t rx_byte;

    modport source (output valid, output operation, output rx_byte, input ready);
    modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

/* rtl/core/afr_out_if.sv */
// Output channel of the addressed frame receiver: valid/ready handshake with
// the reply byte, motor bytes and frame status. Depends on afr_pkg.
`timescale 1ns / 1ps

interface afr_out_if
    import afr_pkg::*;
();
    logic  valid;
    logic  ready;
    logic  tx_valid;
    byte_t tx_byte;
    byte_t motor_low;
    byte_t motor_high;
    logic  frame_accepted;

    modport source (output valid, output tx_valid, output tx_byte, output motor_low,
                    output motor_high, output frame_accepted, input ready);
    modport sink   (input valid, input tx_valid, input tx_byte, input motor_low,
                    input motor_high, input frame_accepted, output ready);
endinterface

/* rtl/core/addressed_frame_receiver_top.sv */
// Addressed frame receiver, top level; depends on afr_pkg, afr_in_if and
// afr_out_if. Each input request is either a received byte or a transmit-done
// event, and produces exactly one result request in the cycle after it is
// accepted. A new request is taken in every cycle while the result register is
// empty or being read, so the sustained rate is one request per cycle; the
// single result register is the only stage. Received bytes drive a seven-byte
// frame parser (start, address, command, data high, data low, trailer, sum);
// a bad command or trailer byte starts a five-byte error reply, when none is
// running, whose first byte comes out with that result and whose remaining
// bytes come out on the following transmit-done events. The node address
// register may be written only while the block is idle.
`timescale 1ns / 1ps

module addressed_frame_receiver_top
    import afr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  byte_t      cfg_data,
    afr_in_if.sink     in_chan,
    afr_out_if.source  out_chan
);

    // Configuration and protocol state.
    byte_t node_addr_reg;
    pos_t  frame_pos_reg, frame_pos_next;
    pos_t  reply_pos_reg, reply_pos_next;
    byte_t sum_reg, sum_next;
    byte_t held_high_reg, held_high_next;
    byte_t held_low_reg, held_low_next;
    byte_t motor_low_reg, motor_low_next;
    byte_t motor_high_reg, motor_high_next;

    // Result register.
    logic  out_valid_reg;
    logic  tx_valid_reg, tx_valid_next;
    byte_t tx_byte_reg, tx_byte_next;
    logic  accepted_reg, accepted_next;

    logic  in_take;
    logic  err_reply;
    byte_t rx;

    // A new request is taken whenever the result register is free or drains now.
    assign in_chan.ready = !out_valid_reg || out_chan.ready;
    assign in_take       = in_chan.valid && in_chan.ready;
    assign rx            = in_chan.rx_byte;

    // Next-state logic for one request.
    always_comb
    begin
        frame_pos_next  = frame_pos_reg;
        reply_pos_next  = reply_pos_reg;
        sum_next        = sum_reg;
        held_high_next  = held_high_reg;
        held_low_next   = held_low_reg;
        motor_low_next  = motor_low_reg;
        motor_high_next = motor_high_reg;
        tx_valid_next   = 1'b0;
        tx_byte_next    = '0;
        accepted_next   = 1'b0;
        err_reply       = 1'b0;

        if (in_chan.operation == OP_RX_BYTE)
        begin
            case (frame_pos_reg)
                FP_START:
                begin
                    if (rx == START_BYTE)
                    begin
                        sum_next       = rx;
                        frame_pos_next = FP_ADDR;
                    end
                end
                FP_ADDR:
                begin
                    if (rx == node_addr_reg)
                    begin
                        sum_next       = sum_reg + rx;
                        frame_pos_next = FP_CMD;
                    end
                    else
                    begin
                        frame_pos_next = FP_START;
                    end
                end
                FP_CMD:
                begin
                    if (rx == CMD_BYTE)
                    begin
                        sum_next       = sum_reg + rx;
                        frame_pos_next = FP_HIGH;
                    end
                    else
                    begin
                        frame_pos_next = FP_START;
                        err_reply      = 1'b1;
                    end
                end
                FP_HIGH:
                begin
                    held_high_next = rx;
                    sum_next       = sum_reg + rx;
                    frame_pos_next = FP_LOW;
                end
                FP_LOW:
                begin
                    held_low_next  = rx;
                    sum_next       = sum_reg + rx;
                    frame_pos_next = FP_TRAIL;
                end
                FP_TRAIL:
                begin
                    if (rx == TRAIL_BYTE)
                    begin
                        sum_next       = sum_reg + rx;
                        frame_pos_next = FP_SUM;
                    end
                    else
                    begin
                        frame_pos_next = FP_START;
                        err_reply      = 1'b1;
                    end
                end
                FP_SUM:
                begin
                    // The parser returns to idle whether or not the sum matches.
                    if (rx == sum_reg)
                    begin
                        motor_low_next  = held_low_reg;
                        motor_high_next = held_high_reg;
                        accepted_next   = 1'b1;
                    end
                    frame_pos_next = FP_START;
                end
                default:
                begin
                    frame_pos_next = FP_START;
                end
            endcase

            // An error starts a reply only when none is already running.
            if (err_reply && reply_pos_reg == RP_IDLE)
            begin
                reply_pos_next = RP_ADDR;
                tx_valid_next  = 1'b1;
                tx_byte_next   = START_BYTE;
            end
        end
        else
        begin
            case (reply_pos_reg)
                RP_ADDR:
                begin
                    tx_valid_next  = 1'b1;
                    tx_byte_next   = node_addr_reg;
                    reply_pos_next = RP_ERR;
                end
                RP_ERR:
                begin
                    tx_valid_next  = 1'b1;
                    tx_byte_next   = ERR_BYTE;
                    reply_pos_next = RP_TRAIL;
                end
                RP_TRAIL:
                begin
                    tx_valid_next  = 1'b1;
                    tx_byte_next   = TRAIL_BYTE;
                    reply_pos_next = RP_SUM;
                end
                RP_SUM:
                begin
                    tx_valid_next  = 1'b1;
                    tx_byte_next   = REPLY_SUM_BASE + node_addr_reg;
                    reply_pos_next = RP_IDLE;
                end
                default:
                begin
                    reply_pos_next = RP_IDLE;
                end
            endcase
        end
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_addr_reg <= '0;
        end
        else if (cfg_we)
        begin
            node_addr_reg <= cfg_data;
        end
    end

    // Protocol state, updated on each accepted request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_pos_reg  <= FP_START;
            reply_pos_reg  <= RP_IDLE;
            sum_reg        <= '0;
            held_high_reg  <= '0;
            held_low_reg   <= '0;
            motor_low_reg  <= '0;
            motor_high_reg <= '0;
        end
        else if (in_take)
        begin
            frame_pos_reg  <= frame_pos_next;
            reply_pos_reg  <= reply_pos_next;
            sum_reg        <= sum_next;
            held_high_reg  <= held_high_next;
            held_low_reg   <= held_low_next;
            motor_low_reg  <= motor_low_next;
            motor_high_reg <= motor_high_next;
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_chan.ready)
        begin
            out_valid_reg <= in_chan.valid;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            tx_valid_reg <= tx_valid_next;
            tx_byte_reg  <= tx_byte_next;
            accepted_reg <= accepted_next;
        end
    end

    // The motor bytes only change when a new result is loaded, so they are
    // read straight from the latched registers.
    assign out_chan.valid          = out_valid_reg;
    assign out_chan.tx_valid       = tx_valid_reg;
    assign out_chan.tx_byte        = tx_byte_reg;
    assign out_chan.motor_low      = motor_low_reg;
    assign out_chan.motor_high     = motor_high_reg;
    assign out_chan.frame_accepted = accepted_reg;

`ifndef NO_ASSERTIONS
    // The reply counter never runs past the checksum byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        reply_pos_reg <= RP_SUM)
        else $error("reply position beyond the checksum byte");

    // A completed frame never sends a reply byte in the same result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && accepted_reg) |-> !tx_valid_reg)
        else $error("reply byte together with an accepted frame");

    // A transmit-done event with no reply running gives an empty result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && in_chan.operation == OP_TX_DONE && reply_pos_reg == RP_IDLE)
        |=> (!tx_valid_reg && !accepted_reg && reply_pos_reg == RP_IDLE))
        else $error("output without an active reply");

    // The checksum byte always returns the parser to the start.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && in_chan.operation == OP_RX_BYTE && frame_pos_reg == FP_SUM)
        |=> (frame_pos_reg == FP_START))
        else $error("parser did not restart after the checksum byte");

    // The motor bytes change only through an accepted frame; the low byte is checked.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$stable(motor_low_reg)) |-> accepted_reg)
        else $error("motor byte changed without an accepted frame");
`endif

endmodule
